// ----- hw/rtl/rbf_pkg.sv -----
// Shared types and codes for the transmit ring buffer.
package rbf_pkg;

    typedef enum logic [1:0] {
        ACT_APPEND  = 2'd0,
        ACT_CONSUME = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    // Register index of the buffer size register (taken from paddr[2]).
    localparam logic REG_BUFFER_SIZE = 1'b0;

    // Chunk byte count field width (chunks carry at most eight bytes).
    localparam int CNT_W = 4;

    typedef struct packed {
        logic             wr_load;   // take a new chunk into the write queue
        logic [CNT_W-1:0] wr_count;  // bytes in that chunk
        logic             rd_en;     // sample the store at the read address
    } t_store_ctl;

    typedef struct packed {
        logic busy;                  // chunk bytes still waiting to be written
    } t_store_stat;

endpackage

// ----- hw/rtl/rbf_lane.sv -----
// One byte lane: store address of chunk byte IDX, wrapped at the buffer size.
module rbf_lane #(
    parameter int IDX = 0,
    parameter int AW  = 12,
    parameter int BW  = 13
) (
    input  logic [AW-1:0] i_wp,
    input  logic [BW-1:0] i_bs,
    output logic [AW-1:0] o_addr
);
    import rbf_pkg::*;

    localparam int LW = BW + 1;

    logic [LW-1:0] sum;
    logic [LW-1:0] wrapped;

    // Only lanes below an accepted chunk length are used, so one wrap suffices.
    assign sum     = LW'(i_wp) + LW'(IDX);
    assign wrapped = (sum >= LW'(i_bs)) ? (sum - LW'(i_bs)) : sum;
    assign o_addr  = wrapped[AW-1:0];

endmodule

// ----- hw/rtl/rbf_store.sv -----
// Byte store with a chunk write queue (one byte a cycle) and a registered read port.
module rbf_store #(
    parameter int DEPTH     = 4096,
    parameter int MAX_CHUNK = 8,
    parameter int AW        = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rbf_pkg::t_store_ctl                 i_ctl,
    input  logic [MAX_CHUNK-1:0][AW-1:0]        i_addr,
    input  logic [MAX_CHUNK-1:0][7:0]           i_bytes,
    input  logic [11:0]                         i_rd_addr,
    output logic [7:0]                          o_rd_byte,
    output rbf_pkg::t_store_stat                o_stat
);
    import rbf_pkg::*;

    logic [7:0]                   mem [DEPTH];
    logic [CNT_W-1:0]             r_cnt;
    logic [MAX_CHUNK-1:0][AW-1:0] r_wa;
    logic [MAX_CHUNK-1:0][7:0]    r_wd;
    logic [7:0]                   r_q;
    logic                         r_rng;
    logic [31:0]                  rd_ext;
    logic                         wr_en;

    assign wr_en  = (r_cnt != '0);
    assign rd_ext = 32'(i_rd_addr);

    // Queue control: load a chunk, then count it down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.wr_load) begin
            r_cnt <= i_ctl.wr_count;
        end else if (wr_en) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Queue payload: shift toward entry 0, which is written each cycle while bytes remain.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_load) begin
            r_wa <= i_addr;
            r_wd <= i_bytes;
        end else if (wr_en) begin
            for (int i = 0; i < MAX_CHUNK - 1; i++) begin
                r_wa[i] <= r_wa[i+1];
                r_wd[i] <= r_wd[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wa[0]] <= r_wd[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_q   <= mem[rd_ext[AW-1:0]];
            r_rng <= (rd_ext < 32'(DEPTH));
        end
    end

    assign o_rd_byte   = r_rng ? r_q : 8'd0;
    assign o_stat.busy = wr_en;

endmodule

// ----- hw/rtl/tx_ring_buffer_with_send_window.sv -----
// Top level: transmit byte ring buffer with a published contiguous send window.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one action per transaction:
//   append a chunk of 1..MAX_CHUNK bytes, consume sent bytes, read one stored
//   byte, or no operation. Output channel (o_out_valid / i_out_ready) returns
//   exactly one result per transaction: accepted flag, window offset/length
//   after the action, empty flag and, for a read, the stored byte.
//   The APB port holds one register, buffer_size (address 0), clamped to
//   2..DEPTH; writing it clears both positions and the window. Write it only
//   while no transaction is in flight.
// Result timing:
//   Append, consume and no-op results appear in the cycle after acceptance;
//   a read result waits for the registered store read port and a pending
//   flag before it appears. Append lanes compute all byte addresses at once,
//   but the store has one write port, so an accepted append holds off the
//   next transaction until all of its bytes are written.
// Reset: positions, window and output valid clear; buffer_size returns to
//   DEPTH. Store contents are undefined until written.
// Stall: while a result waits with i_out_ready low, o_in_ready stays low and
//   the result holds; no transaction is lost.
module tx_ring_buffer_with_send_window #(
    parameter int DEPTH     = 4096,
    parameter int MAX_CHUNK = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_in_action,
    input  logic [63:0] i_in_chunk_data,
    input  logic [3:0]  i_in_chunk_len,
    input  logic [12:0] i_in_consume_len,
    input  logic [11:0] i_in_read_index,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_out_accepted,
    output logic [11:0] o_out_window_offset,
    output logic [12:0] o_out_window_len,
    output logic        o_out_is_empty,
    output logic [7:0]  o_out_read_byte,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rbf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int BW = $clog2(DEPTH + 1);
    localparam int CW = ((BW > 13) ? BW : 13) + 1;

    // Ring state
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_sp, n_sp;
    logic [AW-1:0] r_woff, n_woff;
    logic [BW-1:0] r_wlen, n_wlen;
    logic [BW-1:0] r_bs, n_bs;

    // Output register
    logic        r_out_valid;
    logic        r_rd_pend;
    logic        r_out_is_rd;
    logic        r_acc;
    logic [11:0] r_ooff;
    logic [12:0] r_olen;

    logic        accept;
    logic        cfg_wr;
    logic        ok;
    t_action     act;
    logic [31:0] cfg_v;
    logic [31:0] woff_ext;
    logic [31:0] wlen_ext;

    logic [CW-1:0] wp_c, sp_c, bs_c, len_c, slen_c, sum_c;

    logic [MAX_CHUNK-1:0][AW-1:0] lane_addr;
    logic [MAX_CHUNK-1:0][7:0]    lane_byte;
    t_store_ctl                   st_ctl;
    t_store_stat                  st_stat;
    logic [7:0]                   st_rd_byte;

    // Window length for given positions: run to the buffer end when wrapped.
    function automatic logic [BW-1:0] win_len_of(input logic [AW-1:0] wp,
                                                 input logic [AW-1:0] sp,
                                                 input logic [BW-1:0] bs);
        logic [BW-1:0] wpx;
        logic [BW-1:0] spx;
        wpx = BW'(wp);
        spx = BW'(sp);
        return (wpx < spx) ? (bs - spx) : (wpx - spx);
    endfunction

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_BUFFER_SIZE);
    assign prdata     = (paddr[2] == REG_BUFFER_SIZE) ? 32'(r_bs) : 32'd0;
    assign o_in_ready = !st_stat.busy && !r_rd_pend && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign act        = t_action'(i_in_action);

    // Byte lanes: every chunk byte gets its wrapped store address in parallel.
    for (genvar g = 0; g < MAX_CHUNK; g++) begin : g_lane
        rbf_lane #(
            .IDX (g),
            .AW  (AW),
            .BW  (BW)
        ) u_lane (
            .i_wp   (r_wp),
            .i_bs   (r_bs),
            .o_addr (lane_addr[g])
        );
        assign lane_byte[g] = i_in_chunk_data[8*g +: 8];
    end

    // Merge: apply a size write, or check the accepted action (an append against free space) and advance the positions.
    always_comb begin
        wp_c   = CW'(r_wp);
        sp_c   = CW'(r_sp);
        bs_c   = CW'(r_bs);
        len_c  = CW'(i_in_chunk_len);
        slen_c = CW'(i_in_consume_len);
        sum_c  = '0;
        n_wp   = r_wp;
        n_sp   = r_sp;
        n_woff = r_woff;
        n_wlen = r_wlen;
        n_bs   = r_bs;
        ok     = 1'b0;
        cfg_v  = 32'(pwdata[12:0]);

        if (cfg_wr) begin
            // Clamp the size, then restart the ring as at construction.
            if (cfg_v < 32'd2) begin
                cfg_v = 32'd2;
            end
            if (cfg_v > 32'(DEPTH)) begin
                cfg_v = 32'(DEPTH);
            end
            n_bs   = BW'(cfg_v);
            n_wp   = '0;
            n_sp   = '0;
            n_woff = '0;
            n_wlen = '0;
        end else if (accept) begin
            unique case (act)
                ACT_APPEND: begin
                    // Reject a chunk that is empty, oversized or would fill the ring.
                    if (len_c == '0 || len_c > CW'(MAX_CHUNK)) begin
                        ok = 1'b0;
                    end else if (wp_c < sp_c) begin
                        ok = (len_c + wp_c) < sp_c;
                    end else begin
                        ok = len_c < (bs_c - wp_c + sp_c);
                    end
                    if (ok) begin
                        sum_c = wp_c + len_c;
                        if (sum_c >= bs_c) begin
                            sum_c = sum_c - bs_c;
                        end
                        n_wp = sum_c[AW-1:0];
                        // Refresh the window only when it was empty.
                        if (r_wlen == '0) begin
                            n_woff = r_sp;
                            n_wlen = win_len_of(n_wp, r_sp, r_bs);
                        end
                    end
                end
                ACT_CONSUME: begin
                    sum_c = slen_c + sp_c;
                    if (r_wp == r_sp) begin
                        ok = 1'b0;
                    end else if (wp_c < sp_c) begin
                        ok = (sum_c <= bs_c);
                        if (ok) begin
                            n_sp = (sum_c == bs_c) ? '0 : sum_c[AW-1:0];
                        end
                    end else begin
                        ok = (sum_c <= wp_c);
                        if (ok) begin
                            // Drained: both positions return to zero.
                            if (sum_c == wp_c) begin
                                n_sp = '0;
                                n_wp = '0;
                            end else begin
                                n_sp = sum_c[AW-1:0];
                            end
                        end
                    end
                    if (ok) begin
                        n_woff = n_sp;
                        n_wlen = win_len_of(n_wp, n_sp, r_bs);
                    end
                end
                ACT_READ: begin
                    ok = 1'b1;
                end
                ACT_NOP: begin
                    ok = 1'b0;
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        st_ctl.wr_load  = accept && (act == ACT_APPEND) && ok;
        st_ctl.wr_count = CNT_W'(i_in_chunk_len);
        st_ctl.rd_en    = accept && (act == ACT_READ);
    end

    rbf_store #(
        .DEPTH     (DEPTH),
        .MAX_CHUNK (MAX_CHUNK),
        .AW        (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (st_ctl),
        .i_addr    (lane_addr),
        .i_bytes   (lane_byte),
        .i_rd_addr (i_in_read_index),
        .o_rd_byte (st_rd_byte),
        .o_stat    (st_stat)
    );

    assign woff_ext = 32'(n_woff);
    assign wlen_ext = 32'(n_wlen);

    // Hold ring state; the user must keep config writes and transactions from coinciding (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_sp   <= '0;
            r_woff <= '0;
            r_wlen <= '0;
            r_bs   <= BW'(DEPTH);
        end else begin
            r_wp   <= n_wp;
            r_sp   <= n_sp;
            r_woff <= n_woff;
            r_wlen <= n_wlen;
            r_bs   <= n_bs;
        end
    end

    // Result control: a read waits in a pending flag for the registered store data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_rd_pend <= accept && (act == ACT_READ);
            if (accept && (act != ACT_READ)) begin
                r_out_valid <= 1'b1;
            end else if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, captured with the post-action window.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc       <= ok;
            r_ooff      <= woff_ext[11:0];
            r_olen      <= wlen_ext[12:0];
            r_out_is_rd <= (act == ACT_READ);
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_accepted      = r_acc;
    assign o_out_window_offset = r_ooff;
    assign o_out_window_len    = r_olen;
    assign o_out_is_empty      = (r_olen == 13'd0);
    assign o_out_read_byte     = r_out_is_rd ? st_rd_byte : 8'd0;

`ifndef SYNTHESIS
    a_wp_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_wp) < CW'(r_bs))
        else $error("write position beyond buffer size");

    a_sp_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_sp) < CW'(r_bs))
        else $error("send position beyond buffer size");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |=> r_out_valid)
        else $error("read result not presented after store access");

    a_hold_while_writing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_stat.busy |-> !o_in_ready)
        else $error("transaction taken while chunk bytes still queued");

    a_win_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wlen <= r_bs)
        else $error("send window longer than buffer");
`endif

endmodule

// ----- dv/tx_ring_buffer_with_send_window_tb.sv -----
// Testbench for the transmit ring buffer: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module tx_ring_buffer_with_send_window_tb;
    import rbf_pkg::*;

    localparam int DEPTH         = 4096;
    localparam int MAX_CHUNK     = 8;
    localparam int STALL_LIMIT   = 3000;   // cycles without any transaction
    localparam logic [2:0] BUFSIZE_ADDR = {REG_BUFFER_SIZE, 2'b00};

    // One action as presented on the input channel.
    typedef struct {
        t_action     action;
        logic [63:0] data;
        logic [3:0]  clen;
        logic [12:0] slen;
        logic [11:0] ridx;
    } t_ring_op;

    // One result as returned on the output channel.
    typedef struct {
        logic        accepted;
        logic [11:0] window_offset;
        logic [12:0] window_len;
        logic        is_empty;
        logic [7:0]  read_byte;
    } t_window_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_in_action = '0;
    logic [63:0] i_in_chunk_data = '0;
    logic [3:0]  i_in_chunk_len = '0;
    logic [12:0] i_in_consume_len = '0;
    logic [11:0] i_in_read_index = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_out_accepted;
    logic [11:0] o_out_window_offset;
    logic [12:0] o_out_window_len;
    logic        o_out_is_empty;
    logic [7:0]  o_out_read_byte;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the block state, advanced once per accepted transaction.
    logic [7:0] ring_mem [0:DEPTH-1];
    int ring_size = DEPTH;
    int wr_ptr = 0;
    int snd_ptr = 0;
    int win_start = 0;
    int win_span = 0;
    int max_written = -1;      // writes always start at 0, so [0, max_written] is valid

    t_window_status expected_status_q[$];
    int mismatch_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int idle_cycles = 0;

    tx_ring_buffer_with_send_window #(
        .DEPTH     (DEPTH),
        .MAX_CHUNK (MAX_CHUNK)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_in_action         (i_in_action),
        .i_in_chunk_data     (i_in_chunk_data),
        .i_in_chunk_len      (i_in_chunk_len),
        .i_in_consume_len    (i_in_consume_len),
        .i_in_read_index     (i_in_read_index),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_out_accepted      (o_out_accepted),
        .o_out_window_offset (o_out_window_offset),
        .o_out_window_len    (o_out_window_len),
        .o_out_is_empty      (o_out_is_empty),
        .o_out_read_byte     (o_out_read_byte),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #4 i_clk = ~i_clk;

    // Stall the output channel at random; a zero percentage keeps it always ready.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Publish the contiguous run that starts at the send position.
    function automatic void republish_window();
        win_start = snd_ptr;
        if (wr_ptr < snd_ptr) begin
            win_span = ring_size - snd_ptr;
        end else begin
            win_span = wr_ptr - snd_ptr;
        end
    endfunction

    function automatic void apply_buffer_size(logic [31:0] value);
        int sz;
        sz = int'(value[12:0]);
        if (sz < 2) sz = 2;
        if (sz > DEPTH) sz = DEPTH;
        ring_size = sz;
        wr_ptr = 0;
        snd_ptr = 0;
        republish_window();
    endfunction

    function automatic t_window_status predict_window_status(t_ring_op op);
        t_window_status st;
        bit ok;
        bit was_empty;
        bit fits;
        int n;
        ok = 1'b0;
        st.read_byte = '0;
        case (op.action)
            ACT_APPEND: begin
                was_empty = (win_span == 0);
                n = int'(op.clen);
                // Never let the write position catch up with the send position.
                if (wr_ptr < snd_ptr) begin
                    fits = (n + wr_ptr < snd_ptr);
                end else begin
                    fits = (n < ring_size - wr_ptr + snd_ptr);
                end
                if (n != 0 && n <= MAX_CHUNK && fits) begin
                    for (int i = 0; i < n; i++) begin
                        ring_mem[wr_ptr] = op.data[8*i +: 8];
                        if (wr_ptr > max_written) max_written = wr_ptr;
                        wr_ptr++;
                        if (wr_ptr >= ring_size) wr_ptr = 0;
                    end
                    // A window that already shows data stays as it was.
                    if (was_empty) republish_window();
                    ok = 1'b1;
                end
            end
            ACT_CONSUME: begin
                n = int'(op.slen);
                if (wr_ptr != snd_ptr) begin
                    if (wr_ptr < snd_ptr) begin
                        // Data wraps: the run ends at the buffer end.
                        if (n + snd_ptr <= ring_size) begin
                            snd_ptr += n;
                            if (snd_ptr == ring_size) snd_ptr = 0;
                            ok = 1'b1;
                        end
                    end else if (n + snd_ptr <= wr_ptr) begin
                        snd_ptr += n;
                        // Drained: rewind both positions.
                        if (snd_ptr == wr_ptr) begin
                            snd_ptr = 0;
                            wr_ptr = 0;
                        end
                        ok = 1'b1;
                    end
                    if (ok) republish_window();
                end
            end
            ACT_READ: begin
                ok = 1'b1;
                st.read_byte = ring_mem[op.ridx];
            end
            default: ;
        endcase
        st.accepted = ok;
        st.window_offset = win_start[11:0];
        st.window_len = win_span[12:0];
        st.is_empty = (win_span == 0);
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Build one action; fields the action does not use carry random values.
    function automatic t_ring_op make_op(t_action act, int unsigned arg, logic [63:0] data);
        t_ring_op op;
        op.action = act;
        op.data = {$urandom, $urandom};
        op.clen = 4'($urandom);
        op.slen = 13'($urandom);
        op.ridx = 12'($urandom);
        case (act)
            ACT_APPEND: begin
                op.clen = 4'(arg);
                op.data = data;
            end
            ACT_CONSUME: op.slen = 13'(arg);
            ACT_READ:    op.ridx = 12'(arg);
            default: ;
        endcase
        return op;
    endfunction

    // Mostly legal traffic shaped by the current ring state, plus some noise:
    // bad chunk lengths, random consume lengths and no-ops.
    function automatic t_ring_op next_random_op(int drain_pct, bit fill_mode);
        int pick;
        int run;
        int len;
        pick = $urandom_range(99);
        run = (wr_ptr < snd_ptr) ? ring_size - snd_ptr : wr_ptr - snd_ptr;
        if (pick < (fill_mode ? 80 : 48)) begin
            if ($urandom_range(99) < 6) begin
                len = ($urandom_range(1) != 0) ? 0 : $urandom_range(15, MAX_CHUNK + 1);
            end else if (fill_mode && $urandom_range(9) != 0) begin
                len = MAX_CHUNK;
            end else begin
                len = $urandom_range(MAX_CHUNK, 1);
            end
            return make_op(ACT_APPEND, len, {$urandom, $urandom});
        end
        if (pick < (fill_mode ? 90 : 80)) begin
            if (run == 0 || $urandom_range(99) < 12) begin
                len = $urandom_range(8191, 0);
            end else if (fill_mode) begin
                len = $urandom_range(run / 4, 0);
            end else if ($urandom_range(99) < drain_pct) begin
                len = run;
            end else begin
                len = $urandom_range(run, 0);
            end
            return make_op(ACT_CONSUME, len, '0);
        end
        // Read only bytes that have been written at least once.
        if (pick < 97 && max_written >= 0) begin
            return make_op(ACT_READ, $urandom_range(max_written, 0), '0);
        end
        return make_op(ACT_NOP, 0, '0);
    endfunction

    // Present one transaction, hold it until accepted, then record its predicted result.
    task automatic push_op(input t_ring_op op);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_in_action      <= op.action;
        i_in_chunk_data  <= op.data;
        i_in_chunk_len   <= op.clen;
        i_in_consume_len <= op.slen;
        i_in_read_index  <= op.ridx;
        do @(posedge i_clk); while (!o_in_ready);
        expected_status_q.push_back(predict_window_status(op));
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_status_q.size() != 0);
    endtask

    // APB write of the buffer size register, only once no result is outstanding.
    task automatic set_buffer_size(input logic [31:0] value);
        wait_drained();
        repeat (2) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BUFSIZE_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_buffer_size(value);
    endtask

    task automatic run_traffic(input int count, input int drain_pct, input bit fill_mode);
        repeat (count) push_op(next_random_op(drain_pct, fill_mode));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked corner cases on the default size, a two-byte ring and a
    // ten-byte ring that wraps.
    task automatic test_directed();
        push_op(make_op(ACT_APPEND, 0, {$urandom, $urandom}));        // zero length
        push_op(make_op(ACT_APPEND, 9, {$urandom, $urandom}));        // oversized
        push_op(make_op(ACT_APPEND, 15, {$urandom, $urandom}));
        push_op(make_op(ACT_CONSUME, 5, '0));                          // empty ring
        push_op(make_op(ACT_APPEND, 1, 64'h0000_0000_0000_00A5));
        push_op(make_op(ACT_APPEND, 8, '1));                           // window stays stale
        push_op(make_op(ACT_READ, 0, '0));
        push_op(make_op(ACT_READ, 8, '0));
        push_op(make_op(ACT_CONSUME, 8191, '0));                       // overrun
        push_op(make_op(ACT_CONSUME, 0, '0));                          // zero length refresh
        push_op(make_op(ACT_CONSUME, 3, '0));
        push_op(make_op(ACT_NOP, 0, '0));
        push_op(make_op(ACT_CONSUME, 6, '0));                          // drain to zero
        push_op(make_op(ACT_APPEND, 8, '0));
        push_op(make_op(ACT_READ, 1, '0));

        // Size clamps to two: a single stored byte already fills the ring.
        set_buffer_size(32'd0);
        push_op(make_op(ACT_APPEND, 1, {$urandom, $urandom}));
        push_op(make_op(ACT_APPEND, 1, {$urandom, $urandom}));
        push_op(make_op(ACT_CONSUME, 1, '0));

        // Wrap at the buffer end, then fill checks with the write behind the send.
        set_buffer_size(32'd10);
        push_op(make_op(ACT_APPEND, 8, {$urandom, $urandom}));
        push_op(make_op(ACT_CONSUME, 5, '0));
        push_op(make_op(ACT_APPEND, 4, {$urandom, $urandom}));
        push_op(make_op(ACT_APPEND, 3, {$urandom, $urandom}));
        push_op(make_op(ACT_APPEND, 2, {$urandom, $urandom}));
        push_op(make_op(ACT_CONSUME, 6, '0));
        push_op(make_op(ACT_CONSUME, 5, '0));
        push_op(make_op(ACT_CONSUME, 4, '0));
    endtask

    // Full-size ring filled far past the halfway mark so reads reach store addresses
    // beyond it; the size write is clamped down from its maximum.
    task automatic test_deep_fill();
        set_buffer_size(32'd8191);
        run_traffic(500, 0, 1'b1);
    endtask

    // Small rings where fill rejects, wraps and drains come often.
    task automatic test_small_rings();
        int sizes[5] = '{1, 3, 17, 64, 255};
        foreach (sizes[k]) begin
            set_buffer_size(sizes[k]);
            run_traffic(120, 25, 1'b0);
        end
    endtask

    // Send each transaction only after the previous result has come back.
    task automatic test_drain_pause();
        set_buffer_size(32'd33);
        repeat (40) begin
            wait_drained();
            push_op(next_random_op(20, 1'b0));
        end
    endtask

    // Back-to-back traffic with neither side idling.
    task automatic test_mixed_traffic();
        set_buffer_size(32'd4096);
        run_traffic(250, 10, 1'b0);
        set_buffer_size(32'd129);
        run_traffic(150, 20, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare every result against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_window_status want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_status_q.size() == 0) begin
                $display("%0t: unexpected result: expected none actual offset %0d len %0d",
                         $time, o_out_window_offset, o_out_window_len);
                mismatch_count++;
            end else begin
                want = expected_status_q.pop_front();
                check_field("accepted", 16'(want.accepted), 16'(o_out_accepted));
                check_field("window_offset", 16'(want.window_offset),
                            16'(o_out_window_offset));
                check_field("window_len", 16'(want.window_len), 16'(o_out_window_len));
                check_field("is_empty", 16'(want.is_empty), 16'(o_out_is_empty));
                check_field("read_byte", 16'(want.read_byte), 16'(o_out_read_byte));
            end
        end
    end

    // End the run if nothing moves on either channel or the register port.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tx_ring_buffer_with_send_window test failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender mostly busy, receiver stalling about half the time.
        tx_idle_pct = 7;
        rx_idle_pct = 54;
        test_directed();
        test_deep_fill();

        // Sender gappy, receiver mostly ready.
        tx_idle_pct = 54;
        rx_idle_pct = 7;
        test_small_rings();
        test_drain_pause();

        // No idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_mixed_traffic();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tx_ring_buffer_with_send_window test passed");
        end else begin
            $display("tx_ring_buffer_with_send_window test failed");
        end
        $finish;
    end

endmodule
